/* rtl/bei_pkg.sv */
// Shared types, constants and the noise generator step for the burst error injector.
`timescale 1ns / 1ps
package bei_pkg;

    // Generator reset value and xorshift32 shift amounts
    localparam logic [31:0] PRNG_RESET = 32'hDEADC0DE;
    localparam int          SHIFT_A    = 13;
    localparam int          SHIFT_B    = 17;
    localparam int          SHIFT_C    = 5;

    // Remainder divider: one quotient bit per step over a 32-bit dividend
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register file: 8-bit burst length at byte address 0, 32-bit seed at byte address 4
    localparam int CFG_ADDR_W = 3;

    typedef enum logic {
        REG_BURST_LEN = 1'b0,
        REG_SEED      = 1'b1
    } t_reg_idx;

    // Input word
    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
        logic        first_byte;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [7:0] out_byte;
        logic       corrupted;
        logic       error;
    } t_out_word;

    // Classified word handed from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       error;
        logic [7:0] burst;
    } t_cls;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Back-end sequencer
    typedef enum logic [1:0] {
        BK_RUN,
        BK_DIV,
        BK_FIN
    } t_back_state;

    // One xorshift32 step
    function automatic logic [31:0] xs32_next(input logic [31:0] x);
        logic [31:0] v;
        v = x;
        v = v ^ (v << SHIFT_A);
        v = v ^ (v >> SHIFT_B);
        v = v ^ (v << SHIFT_C);
        return v;
    endfunction

endpackage

/* rtl/burst_error_injector_top.sv */
// Top level of the burst error injector: register file, front end, queue and back end.
`timescale 1ns / 1ps
//
//  port group   handshake                    word
//  ----------   --------------------------   -----------------------------------
//  input        i_in_valid / o_in_ready      i_in_word  (data, frame length, first)
//  output       o_out_valid / i_out_ready    o_out_word (byte, corrupted, error)
//  registers    psel/penable/pwrite, pready  paddr, pwdata, prdata
//
//  A word that does not open a valid frame passes from the queue head straight into the
//  output register, so such words stream at one per cycle while the output takes them.
//  The first word of a frame with a nonzero burst holds the queue head through one draw,
//  32 divider steps, the done pulse and a final step that finishes the word.
//  The two-entry queue, whose head is the word in work, fills while the back end divides
//  or the output stalls, then o_in_ready drops. Reset is synchronous and active low; no
//  clearing pass is needed.
//
module burst_error_injector_top
    import bei_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int Q_WIDTH = LENGTH_WIDTH + $bits(t_cls);

    logic [7:0]              r_burst_len;
    logic [31:0]             r_seed;
    logic                    cfg_wr;
    t_reg_idx                reg_idx;
    logic                    seed_load;

    logic                    push;
    logic                    pop;
    t_cls                    front_cls;
    logic [LENGTH_WIDTH-1:0] front_divisor;
    t_q_stat                 q_stat;
    logic [Q_WIDTH-1:0]      q_head;
    t_cls                    head_cls;
    logic [LENGTH_WIDTH-1:0] head_divisor;

    // Register port: the register index is the word address
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign reg_idx   = t_reg_idx'(paddr[CFG_ADDR_W-1]);
    assign seed_load = cfg_wr && (reg_idx == REG_SEED) && (pwdata != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_len <= 8'd1;
            r_seed      <= PRNG_RESET;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_BURST_LEN: r_burst_len <= pwdata[7:0];
                REG_SEED:      r_seed      <= pwdata;
                default:       r_seed      <= r_seed;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_BURST_LEN: prdata = {24'd0, r_burst_len};
            REG_SEED:      prdata = r_seed;
            default:       prdata = 32'd0;
        endcase
    end

    bei_front #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_front (
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_burst_len (r_burst_len),
        .i_q_stat    (q_stat),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_cls       (front_cls),
        .o_divisor   (front_divisor)
    );

    bei_queue #(
        .WIDTH(Q_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({front_divisor, front_cls}),
        .i_pop   (pop),
        .o_data  (q_head),
        .o_stat  (q_stat)
    );

    assign head_cls     = q_head[$bits(t_cls)-1:0];
    assign head_divisor = q_head[Q_WIDTH-1:$bits(t_cls)];

    bei_back #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_seed_load    (seed_load),
        .i_seed         (pwdata),
        .i_q_valid      (!q_stat.empty),
        .i_head         (head_cls),
        .i_head_divisor (head_divisor),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .o_out_word     (o_out_word),
        .i_out_ready    (i_out_ready)
    );

    // A replaced byte never belongs to an error frame
    a_corrupt_not_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.corrupted |-> !o_out_word.error)
        else $error("corrupted byte flagged as error frame");

    // Noise is only injected while a burst length is set
    a_corrupt_needs_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.corrupted |-> (r_burst_len != 8'd0))
        else $error("corrupted byte with zero burst length");

    // A new output word always comes from a queued word
    a_out_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!q_stat.empty))
        else $error("output word produced from an empty queue");

    // The queue is never pushed while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |=> !(q_stat.full && $past(push) && !$past(pop)) || $past(!push))
        else $error("queue overflow");

endmodule

/* rtl/bei_front.sv */
// Front end: accepts input words, caps the burst and works out the start divisor.
`timescale 1ns / 1ps
module bei_front
    import bei_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    i_in_valid,
    input  t_in_word                i_in_word,
    input  logic [7:0]              i_burst_len,
    input  t_q_stat                 i_q_stat,
    output logic                    o_in_ready,
    output logic                    o_push,
    output t_cls                    o_cls,
    output logic [LENGTH_WIDTH-1:0] o_divisor
);

    logic [LENGTH_WIDTH-1:0] flen;
    logic [LENGTH_WIDTH-1:0] burst_ext;
    logic [LENGTH_WIDTH-1:0] burst_cap;

    // Take a word whenever the queue has room
    assign o_in_ready = !i_q_stat.full;
    assign o_push     = i_in_valid && !i_q_stat.full;

    // Cap the burst to the frame length and flag empty bursts or frames
    always_comb begin
        flen      = LENGTH_WIDTH'(i_in_word.frame_length);
        burst_ext = LENGTH_WIDTH'(i_burst_len);
        burst_cap = (burst_ext > flen) ? flen : burst_ext;

        o_cls.data_byte  = i_in_word.data_byte;
        o_cls.first_byte = i_in_word.first_byte;
        o_cls.error      = (i_burst_len == 8'd0) || (flen == '0);
        o_cls.burst      = burst_cap[7:0];
        o_divisor        = flen - burst_cap + LENGTH_WIDTH'(1);
    end

endmodule

/* rtl/bei_queue.sv */
// Short queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module bei_queue
    import bei_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    logic [WIDTH-1:0]   r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_stat.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_data       = r_mem[r_rptr];

    // Store pushed words
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Advance pointers and track the fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/bei_div.sv */
// Restoring remainder divider: 32-bit dividend, one bit per cycle.
`timescale 1ns / 1ps
module bei_div
    import bei_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [31:0]             i_dividend,
    input  logic [LENGTH_WIDTH-1:0] i_divisor,
    output logic                    o_done,
    output logic [LENGTH_WIDTH-1:0] o_rem
);

    logic [31:0]             r_dvd;
    logic [LENGTH_WIDTH-1:0] r_dvs;
    logic [LENGTH_WIDTH-1:0] r_rem;
    logic [DIV_CNT_W-1:0]    r_cnt;
    logic                    r_done;
    logic [LENGTH_WIDTH:0]   trial;
    logic [LENGTH_WIDTH:0]   diff;

    assign o_done = r_done;
    assign o_rem  = r_rem;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {r_rem, r_dvd[31]};
        diff  = trial - {1'b0, r_dvs};
    end

    // Control: count the steps and pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == DIV_CNT_W'(1));
            if (i_start) begin
                r_cnt <= DIV_CNT_W'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= r_dvd << 1;
            r_rem <= trial[LENGTH_WIDTH] || (trial >= {1'b0, r_dvs})
                     ? diff[LENGTH_WIDTH-1:0] : trial[LENGTH_WIDTH-1:0];
        end
    end

endmodule

/* rtl/bei_back.sv */
// Back end: owns the generator and frame state, places the burst and drives the output word.
`timescale 1ns / 1ps
module bei_back
    import bei_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_seed_load,
    input  logic [31:0]             i_seed,
    input  logic                    i_q_valid,
    input  t_cls                    i_head,
    input  logic [LENGTH_WIDTH-1:0] i_head_divisor,
    output logic                    o_pop,
    output logic                    o_out_valid,
    output t_out_word               o_out_word,
    input  logic                    i_out_ready
);

    localparam logic [LENGTH_WIDTH-1:0] POS_MAX = '1;

    t_back_state             r_state;
    t_back_state             n_state;
    logic [31:0]             r_prng;
    logic [LENGTH_WIDTH-1:0] r_pos;
    logic [LENGTH_WIDTH-1:0] r_start;
    logic [7:0]              r_remain;
    logic                    r_ferr;
    logic                    r_out_valid;
    t_out_word               r_out_word;

    logic                    slot_free;
    logic                    err_start;
    logic                    div_start;
    logic                    emit;
    logic                    hit;
    logic                    eff_err;
    logic [LENGTH_WIDTH-1:0] eff_pos;
    logic [LENGTH_WIDTH-1:0] eff_start;
    logic [7:0]              eff_remain;
    logic [31:0]             draw;
    logic                    div_done;
    logic [LENGTH_WIDTH-1:0] div_rem;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign draw        = xs32_next(r_prng);
    assign slot_free   = !r_out_valid || i_out_ready;

    // Burst start: generator word modulo the free span of the frame
    bei_div #(
        .LENGTH_WIDTH(LENGTH_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (draw),
        .i_divisor  (i_head_divisor),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_RUN: begin
                if (div_start) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_FIN;
                end
            end
            BK_FIN: begin
                if (slot_free) begin
                    n_state = BK_RUN;
                end
            end
            default: n_state = BK_RUN;
        endcase
    end

    // Outputs of the sequencer and the per-word decision
    always_comb begin
        div_start = 1'b0;
        emit      = 1'b0;
        err_start = 1'b0;
        case (r_state)
            BK_RUN: begin
                div_start = i_q_valid && i_head.first_byte && !i_head.error;
                emit      = i_q_valid && slot_free && !(i_head.first_byte && !i_head.error);
                err_start = i_head.first_byte;
            end
            BK_FIN: begin
                emit = i_q_valid && slot_free;
            end
            default: begin
                emit = 1'b0;
            end
        endcase

        // A first word reaching here without a divide is an error frame
        eff_err    = err_start ? 1'b1 : r_ferr;
        eff_pos    = err_start ? '0   : r_pos;
        eff_start  = err_start ? '0   : r_start;
        eff_remain = err_start ? '0   : r_remain;
        hit        = !eff_err && (eff_remain != 8'd0) && (eff_pos >= eff_start);
        o_pop      = emit;
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // Generator and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prng   <= PRNG_RESET;
            r_pos    <= '0;
            r_start  <= '0;
            r_remain <= '0;
            r_ferr   <= 1'b0;
        end else begin
            // Advance the generator on the start draw and on each noise byte
            if (i_seed_load) begin
                r_prng <= i_seed;
            end else if (div_start || (emit && hit)) begin
                r_prng <= draw;
            end

            if (div_start) begin
                r_pos    <= '0;
                r_remain <= i_head.burst;
                r_ferr   <= 1'b0;
            end else if (emit) begin
                r_pos    <= (eff_pos < POS_MAX) ? eff_pos + 1'b1 : eff_pos;
                r_remain <= hit ? eff_remain - 8'd1 : eff_remain;
                r_ferr   <= eff_err;
                r_start  <= eff_start;
            end else if ((r_state == BK_DIV) && div_done) begin
                r_start <= div_rem;
            end
        end
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_word.out_byte  <= hit ? draw[7:0] : i_head.data_byte;
            r_out_word.corrupted <= hit;
            r_out_word.error     <= eff_err;
        end
    end

endmodule

/* dv/tb_burst_error_injector_top.sv */
// Testbench for the burst error injector: predicts each output word and checks it.
`timescale 1ns / 1ps
module tb_burst_error_injector_top;
    import bei_pkg::*;

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_ready = 1'b0;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr     = '0;
    logic [31:0]           pwdata    = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_word;
    logic [31:0]           prdata;
    logic                  pready;

    // Predicted injector state and register copies
    logic [31:0] noise_state   = PRNG_RESET;
    logic [15:0] frame_pos     = '0;
    logic [15:0] burst_begin   = '0;
    logic [7:0]  burst_left    = '0;
    logic        frame_err     = 1'b0;
    logic [7:0]  burst_len_reg = 8'd1;
    logic [31:0] seed_reg      = PRNG_RESET;

    t_out_word   pending_out_words[$];
    int          mismatch_count = 0;
    bit          idling_off     = 1'b0;
    int          stall_left     = 0;

    burst_error_injector_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 i_clk = ~i_clk;

    // Advance the xorshift32 noise generator by one draw
    function automatic logic [31:0] draw_noise();
        noise_state = noise_state ^ (noise_state << SHIFT_A);
        noise_state = noise_state ^ (noise_state >> SHIFT_B);
        noise_state = noise_state ^ (noise_state << SHIFT_C);
        return noise_state;
    endfunction

    // Work out the output word for one accepted input word
    function automatic t_out_word predict_out_word(input t_in_word w);
        t_out_word   r;
        logic [15:0] cap;
        logic [31:0] span;
        logic [31:0] noise;
        r.out_byte  = w.data_byte;
        r.corrupted = 1'b0;
        if (w.first_byte) begin
            frame_pos = '0;
            if (burst_len_reg == 8'd0 || w.frame_length == 16'd0) begin
                frame_err   = 1'b1;
                burst_begin = '0;
                burst_left  = '0;
            end else begin
                cap         = (16'(burst_len_reg) > w.frame_length) ? w.frame_length
                                                                    : 16'(burst_len_reg);
                frame_err   = 1'b0;
                span        = 32'(w.frame_length) - 32'(cap) + 32'd1;
                burst_begin = 16'(draw_noise() % span);
                burst_left  = cap[7:0];
            end
        end
        if (!frame_err && burst_left != 8'd0 && frame_pos >= burst_begin) begin
            noise       = draw_noise();
            r.out_byte  = noise[7:0];
            r.corrupted = 1'b1;
            burst_left  = burst_left - 8'd1;
        end
        // Saturate the position counter rather than wrap
        if (frame_pos != 16'hFFFF) begin
            frame_pos = frame_pos + 16'd1;
        end
        r.error = frame_err;
        return r;
    endfunction

    // Compare one output word with the oldest prediction
    task automatic check_out_word(input t_out_word got);
        t_out_word exp_word;
        if (pending_out_words.size() == 0) begin
            $error("unexpected output word %h", got);
            mismatch_count++;
        end else begin
            exp_word = pending_out_words.pop_front();
            if (got.out_byte !== exp_word.out_byte) begin
                $error("out_byte: expected %h, got %h", exp_word.out_byte, got.out_byte);
                mismatch_count++;
            end
            if (got.corrupted !== exp_word.corrupted) begin
                $error("corrupted: expected %b, got %b", exp_word.corrupted, got.corrupted);
                mismatch_count++;
            end
            if (got.error !== exp_word.error) begin
                $error("error: expected %b, got %b", exp_word.error, got.error);
                mismatch_count++;
            end
        end
    endtask

    // Check accepted output words and stall the output side in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            check_out_word(o_out_word);
        end
        if (idling_off) begin
            out_ready  <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            stall_left = $urandom_range(0, 14);
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Send one input word, with an occasional gap before it, and predict its output
    task automatic send_word(input t_in_word w);
        if (!idling_off && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        pending_out_words.push_back(predict_out_word(w));
    endtask

    // Send a frame: a first word declaring the length, then the remaining words
    task automatic send_frame(input logic [15:0] declared_len, input int word_count);
        t_in_word w;
        for (int i = 0; i < word_count; i++) begin
            w.data_byte    = 8'($urandom);
            w.frame_length = (i == 0) ? declared_len : 16'($urandom);
            w.first_byte   = (i == 0);
            send_word(w);
        end
    endtask

    // Drop valid, wait for every predicted word, then let the divider settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_out_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Write one register over the APB port once the block has gone idle, then read it back
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value);
        logic [31:0] exp_rd;
        wait_idle();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        exp_rd  = 32'd0;
        case (idx)
            REG_BURST_LEN: begin
                burst_len_reg = value[7:0];
                exp_rd        = {24'd0, burst_len_reg};
            end
            REG_SEED: begin
                seed_reg = value;
                exp_rd   = seed_reg;
                if (value != 32'd0) begin
                    noise_state = value;
                end
            end
            default: begin
            end
        endcase
        @(posedge i_clk);
        if (prdata !== exp_rd) begin
            $error("prdata: expected %h, got %h", exp_rd, prdata);
            mismatch_count++;
        end
    endtask

    // Bytes before any frame has started pass unchanged
    task automatic test_stray_words();
        t_in_word w;
        w = '{data_byte: 8'h00, frame_length: 16'hFFFF, first_byte: 1'b0};
        send_word(w);
        w = '{data_byte: 8'hFF, frame_length: 16'h0000, first_byte: 1'b0};
        send_word(w);
    endtask

    // Reset settings, then length capping on the shortest and longest frames
    task automatic test_frame_extremes();
        send_frame(16'd4, 4);
        write_reg(REG_BURST_LEN, 32'd255);
        send_frame(16'd1, 1);
        send_frame(16'hFFFF, 3);
        send_frame(16'd5, 5);
    endtask

    // Zero burst, zero frame length, and words beyond the declared length
    task automatic test_error_frames();
        write_reg(REG_BURST_LEN, 32'd0);
        send_frame(16'd3, 3);
        write_reg(REG_BURST_LEN, 32'd3);
        send_frame(16'd0, 2);
        write_reg(REG_BURST_LEN, 32'd2);
        send_frame(16'd2, 4);
    endtask

    // A zero seed leaves the generator alone; nonzero seeds reload it
    task automatic test_seed_writes();
        write_reg(REG_SEED, 32'd0);
        send_frame(16'd2, 2);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        send_frame(16'd2, 2);
        write_reg(REG_SEED, 32'd1);
        send_frame(16'd3, 3);
    endtask

    // Mostly well-formed frames, some truncated or overlong, some stray words
    task automatic run_random_traffic(input int word_budget);
        int       sent;
        int       kind;
        int       len;
        t_in_word w;
        sent = 0;
        while (sent < word_budget) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 600)
                                                  : $urandom_range(1, 48);
                send_frame(16'(len), len);
            end else if (kind == 8) begin
                len = $urandom_range(1, 8);
                send_frame(16'($urandom), len);
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    w.data_byte    = 8'($urandom);
                    w.frame_length = 16'($urandom);
                    w.first_byte   = 1'b0;
                    send_word(w);
                end
            end
            sent += len;
        end
    endtask

    // Several register settings, the extremes among them; the last phase runs flat out
    task automatic test_random_phases();
        write_reg(REG_BURST_LEN, 32'd1);
        write_reg(REG_SEED, $urandom);
        run_random_traffic(280);
        write_reg(REG_BURST_LEN, 32'd255);
        write_reg(REG_SEED, $urandom);
        run_random_traffic(300);
        write_reg(REG_BURST_LEN, 32'd0);
        run_random_traffic(120);
        write_reg(REG_BURST_LEN, $urandom_range(2, 16));
        write_reg(REG_SEED, 32'd0);
        run_random_traffic(300);
        write_reg(REG_BURST_LEN, $urandom_range(1, 255));
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        run_random_traffic(300);
        write_reg(REG_BURST_LEN, $urandom_range(1, 32));
        write_reg(REG_SEED, $urandom);
        idling_off = 1'b1;
        run_random_traffic(300);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stray_words();
        test_frame_extremes();
        test_error_frames();
        test_seed_writes();
        test_random_phases();
        wait_idle();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
